// ===== rtl/core/tpw_pkg.sv =====
// ----------------------------------------------------------------------------
// Tilt posture check package
// Shared constants, types and the arctangent table for the tilt check block.
// ----------------------------------------------------------------------------
package tpw_pkg;

  // Number of CORDIC iterations, one cell each.
  localparam int unsigned CORDIC_STAGES = 16;
  // Square root steps, one result bit per cell for a 32-bit radicand.
  localparam int unsigned SQRT_STEPS    = 16;
  // Multiply, sum, square, radicand, square root, CORDIC, output register.
  localparam int unsigned LATENCY       = 5 + SQRT_STEPS + CORDIC_STAGES;
  // Delay line that carries the averages beside the square root and CORDIC.
  localparam int unsigned LINE_LEN      = SQRT_STEPS + CORDIC_STAGES;

  localparam int unsigned VEC_W = 28;  // CORDIC vector width
  localparam int unsigned ACC_W = 24;  // CORDIC angle accumulator width

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_BASE_PITCH = 3'd1;
  localparam logic [2:0] REG_BASE_ROLL = 3'd2;
  localparam logic [2:0] REG_W_FIRST = 3'd3;
  localparam logic [2:0] REG_W_SECOND = 3'd4;
  localparam logic [2:0] REG_W_THIRD = 3'd5;

  // Plus and minus ninety degrees in 1/64 degree with 8 fraction bits; the limit is 180 degrees in 1/64 degree.
  localparam logic signed [ACC_W-1:0] QUARTER_TURN = 24'sd1474560;
  localparam logic signed [14:0] ANGLE_LIMIT = 15'sd11520;

  typedef struct packed {
    logic [13:0]        threshold;
    logic signed [14:0] base_pitch;
    logic signed [14:0] base_roll;
    logic [8:0]         w_first;
    logic [8:0]         w_second;
    logic [8:0]         w_third;
  } tpw_cfg_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } avg_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] res;
  } sq_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ACC_W-1:0] acc;
    logic                    zero;
  } cd_vec_t;

  // atan(2^-i) in degrees times 16384.
  function automatic logic signed [ACC_W-1:0] atan_val(input logic [4:0] idx);
    logic signed [ACC_W-1:0] v;
    case (idx)
      5'd0:  v = 24'sd737280;
      5'd1:  v = 24'sd435242;
      5'd2:  v = 24'sd229970;
      5'd3:  v = 24'sd116736;
      5'd4:  v = 24'sd58595;
      5'd5:  v = 24'sd29326;
      5'd6:  v = 24'sd14667;
      5'd7:  v = 24'sd7334;
      5'd8:  v = 24'sd3667;
      5'd9:  v = 24'sd1833;
      5'd10: v = 24'sd917;
      5'd11: v = 24'sd458;
      5'd12: v = 24'sd229;
      5'd13: v = 24'sd115;
      5'd14: v = 24'sd57;
      5'd15: v = 24'sd29;
      5'd16: v = 24'sd14;
      5'd17: v = 24'sd7;
      5'd18: v = 24'sd4;
      5'd19: v = 24'sd2;
      5'd20: v = 24'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/tpw_cfg.sv =====
// ----------------------------------------------------------------------------
// Tilt posture configuration registers
// APB-style register file for threshold, baselines and sensor weights.
// ----------------------------------------------------------------------------
module tpw_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output tpw_pkg::tpw_cfg_t  cfg_o
);

  tpw_pkg::tpw_cfg_t cfg_q, cfg_d;
  logic [2:0] idx;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Decode a write request in its access cycle.
  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      case (idx)
        tpw_pkg::REG_THRESHOLD:  cfg_d.threshold  = pwdata[13:0];
        tpw_pkg::REG_BASE_PITCH: cfg_d.base_pitch = pwdata[14:0];
        tpw_pkg::REG_BASE_ROLL:  cfg_d.base_roll  = pwdata[14:0];
        tpw_pkg::REG_W_FIRST:    cfg_d.w_first    = pwdata[8:0];
        tpw_pkg::REG_W_SECOND:   cfg_d.w_second   = pwdata[8:0];
        tpw_pkg::REG_W_THIRD:    cfg_d.w_third    = pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold  <= 14'd1920;
      cfg_q.base_pitch <= -15'sd2970;
      cfg_q.base_roll  <= 15'sd831;
      cfg_q.w_first    <= 9'd102;
      cfg_q.w_second   <= 9'd102;
      cfg_q.w_third    <= 9'd51;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back the addressed register.
  always_comb begin
    case (idx)
      tpw_pkg::REG_THRESHOLD:  prdata = {18'd0, cfg_q.threshold};
      tpw_pkg::REG_BASE_PITCH: prdata = 32'(cfg_q.base_pitch);
      tpw_pkg::REG_BASE_ROLL:  prdata = 32'(cfg_q.base_roll);
      tpw_pkg::REG_W_FIRST:    prdata = {23'd0, cfg_q.w_first};
      tpw_pkg::REG_W_SECOND:   prdata = {23'd0, cfg_q.w_second};
      tpw_pkg::REG_W_THIRD:    prdata = {23'd0, cfg_q.w_third};
      default:                 prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/tpw_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// Square root cell
// One step of the bitwise integer square root, registered.
// ----------------------------------------------------------------------------
module tpw_sqrt_cell (
  input  logic          clk_i,
  input  logic [31:0]   bit_i,
  input  tpw_pkg::sq_t  in_i,
  output tpw_pkg::sq_t  out_o
);

  tpw_pkg::sq_t out_d;
  logic [31:0]  trial;

  // Subtract the trial value when it fits and set this result bit.
  always_comb begin
    trial = in_i.res + bit_i;
    if (in_i.rem >= trial) begin
      out_d.rem = in_i.rem - trial;
      out_d.res = (in_i.res >> 1) + bit_i;
    end else begin
      out_d.rem = in_i.rem;
      out_d.res = in_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    out_o <= out_d;
  end

endmodule

// ===== rtl/core/tpw_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// CORDIC cell
// One vectoring iteration: rotates toward the x axis and accumulates angle.
// ----------------------------------------------------------------------------
module tpw_cordic_cell (
  input  logic                                clk_i,
  input  logic [4:0]                          shift_i,
  input  logic signed [tpw_pkg::ACC_W-1:0]    angle_i,
  input  tpw_pkg::cd_vec_t                    in_i,
  output tpw_pkg::cd_vec_t                    out_o
);

  tpw_pkg::cd_vec_t           out_d;
  logic signed [tpw_pkg::VEC_W-1:0] xs, ys;

  // Turn clockwise while y is not negative, counterclockwise otherwise.
  always_comb begin
    xs         = in_i.x >>> shift_i;
    ys         = in_i.y >>> shift_i;
    out_d.zero = in_i.zero;
    if (!in_i.y[tpw_pkg::VEC_W-1]) begin
      out_d.x   = in_i.x + ys;
      out_d.y   = in_i.y - xs;
      out_d.acc = in_i.acc + angle_i;
    end else begin
      out_d.x   = in_i.x - ys;
      out_d.y   = in_i.y + xs;
      out_d.acc = in_i.acc - angle_i;
    end
  end

  always_ff @(posedge clk_i) begin
    out_o <= out_d;
  end

endmodule

// ===== rtl/core/tilt_posture_window_check.sv =====
// ----------------------------------------------------------------------------
// Tilt posture window check
// Weighted accelerometer average, pitch and roll, baseline window compare.
// ----------------------------------------------------------------------------
// Usage: present nine raw samples (three sensors, three axes) with start_i.
// A request is taken at every clock edge where start_i is high and busy_o is
// low; busy_o stays low, so a new request can enter every cycle.
// Each request gives one result: done_o is high for one cycle with the
// averages, angles, errors and posture_good on the result ports. The result
// passes through the multiply, sum, square and radicand stages, then the chain
// of square root cells (one bit each), the chain of CORDIC cells (one
// iteration each) and the output register; the chains are shared by nothing.
// Throughput is one request per cycle. The receiver cannot stall: results
// must be taken in the cycle that done_o marks.
// The APB-style port sets threshold, baselines and weights; write it only
// while no request is in flight. Reset clears the valid pipeline and restores
// the default registers; requests in flight when reset is asserted are lost.
// ----------------------------------------------------------------------------
module tilt_posture_window_check (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [15:0] first_x_i,
  input  logic signed [15:0] first_y_i,
  input  logic signed [15:0] first_z_i,
  input  logic signed [15:0] second_x_i,
  input  logic signed [15:0] second_y_i,
  input  logic signed [15:0] second_z_i,
  input  logic signed [15:0] third_x_i,
  input  logic signed [15:0] third_y_i,
  input  logic signed [15:0] third_z_i,
  output logic               done_o,
  output logic signed [15:0] avg_x_o,
  output logic signed [15:0] avg_y_o,
  output logic signed [15:0] avg_z_o,
  output logic signed [14:0] pitch_angle_o,
  output logic signed [14:0] roll_angle_o,
  output logic signed [15:0] pitch_error_o,
  output logic signed [15:0] roll_error_o,
  output logic               posture_good_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned S = tpw_pkg::SQRT_STEPS;
  localparam int unsigned C = tpw_pkg::CORDIC_STAGES;

  tpw_pkg::tpw_cfg_t cfg;

  tpw_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign busy_o = 1'b0;

  // Valid bits for the four front stages and the two cell chains.
  logic [3:0]                   vf_q;
  logic [tpw_pkg::LINE_LEN-1:0] vl_q;
  logic                         done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q   <= '0;
      vl_q   <= '0;
      done_q <= 1'b0;
    end else begin
      vf_q   <= {vf_q[2:0], start_i};
      vl_q   <= {vl_q[tpw_pkg::LINE_LEN-2:0], vf_q[3]};
      done_q <= vl_q[tpw_pkg::LINE_LEN-1];
    end
  end

  // Stage 1: nine weight products.
  logic signed [25:0] p_q [9];
  logic signed [9:0]  wf, ws, wt;
  assign wf = $signed({1'b0, cfg.w_first});
  assign ws = $signed({1'b0, cfg.w_second});
  assign wt = $signed({1'b0, cfg.w_third});

  always_ff @(posedge clk_i) begin
    p_q[0] <= wf * first_x_i;
    p_q[1] <= wf * first_y_i;
    p_q[2] <= wf * first_z_i;
    p_q[3] <= ws * second_x_i;
    p_q[4] <= ws * second_y_i;
    p_q[5] <= ws * second_z_i;
    p_q[6] <= wt * third_x_i;
    p_q[7] <= wt * third_y_i;
    p_q[8] <= wt * third_z_i;
  end

  // Stage 2: sum, round half up, saturate.
  function automatic logic signed [15:0] avg_round(input logic signed [25:0] a,
                                                   input logic signed [25:0] b,
                                                   input logic signed [25:0] c);
    logic signed [27:0] s;
    logic signed [19:0] q;
    s = 28'(a) + 28'(b) + 28'(c) + 28'sd128;
    q = 20'(s >>> 8);
    if (q > 20'sd32767)       return 16'sh7fff;
    else if (q < -20'sd32768) return 16'sh8000;
    else                      return q[15:0];
  endfunction

  tpw_pkg::avg_t avg2_q, avg3_q, avg4_q;

  always_ff @(posedge clk_i) begin
    avg2_q.x <= avg_round(p_q[0], p_q[3], p_q[6]);
    avg2_q.y <= avg_round(p_q[1], p_q[4], p_q[7]);
    avg2_q.z <= avg_round(p_q[2], p_q[5], p_q[8]);
  end

  // Stage 3: squares of y and z.
  logic signed [31:0] sqy_q, sqz_q;
  always_ff @(posedge clk_i) begin
    sqy_q  <= avg2_q.y * avg2_q.y;
    sqz_q  <= avg2_q.z * avg2_q.z;
    avg3_q <= avg2_q;
  end

  // Stage 4: radicand.
  tpw_pkg::sq_t sq4_q;
  always_ff @(posedge clk_i) begin
    sq4_q.rem <= $unsigned(sqy_q) + $unsigned(sqz_q);
    sq4_q.res <= '0;
    avg4_q    <= avg3_q;
  end

  // Averages ride beside the cell chains.
  tpw_pkg::avg_t line_q [tpw_pkg::LINE_LEN];
  always_ff @(posedge clk_i) begin
    line_q[0] <= avg4_q;
    for (int k = 1; k < int'(tpw_pkg::LINE_LEN); k++) begin
      line_q[k] <= line_q[k-1];
    end
  end

  // Square root chain.
  tpw_pkg::sq_t sq_c [S];
  for (genvar k = 0; k < S; k++) begin : g_sqrt
    tpw_pkg::sq_t sq_in;
    if (k == 0) begin : g_first
      assign sq_in = sq4_q;
    end else begin : g_next
      assign sq_in = sq_c[k-1];
    end
    tpw_sqrt_cell u_cell (
      .clk_i (clk_i),
      .bit_i (32'd1 << (30 - 2 * k)),
      .in_i  (sq_in),
      .out_o (sq_c[k])
    );
  end

  // Set up a CORDIC vector: scale, flag the zero vector, pre-rotate a
  // vector in the left half plane by a quarter turn.
  function automatic tpw_pkg::cd_vec_t cd_prep(input logic signed [17:0] dx,
                                               input logic signed [17:0] ny);
    tpw_pkg::cd_vec_t v;
    logic signed [tpw_pkg::VEC_W-1:0] x, y;
    x = tpw_pkg::VEC_W'(dx) <<< 8;
    y = tpw_pkg::VEC_W'(ny) <<< 8;
    v.zero = (dx == '0) && (ny == '0);
    if (x < 0) begin
      if (y >= 0) begin
        v.x = y;
        v.y = -x;
        v.acc = tpw_pkg::QUARTER_TURN;
      end else begin
        v.x = -y;
        v.y = x;
        v.acc = -tpw_pkg::QUARTER_TURN;
      end
    end else begin
      v.x = x;
      v.y = y;
      v.acc = '0;
    end
    return v;
  endfunction

  tpw_pkg::avg_t    avg_s;
  tpw_pkg::cd_vec_t pitch_in, roll_in;
  assign avg_s    = line_q[S-1];
  assign pitch_in = cd_prep($signed({1'b0, sq_c[S-1].res[16:0]}), 18'(avg_s.x));
  assign roll_in  = cd_prep(18'(avg_s.z), 18'(avg_s.y));

  // Two CORDIC chains, pitch and roll, side by side.
  tpw_pkg::cd_vec_t pc [C];
  tpw_pkg::cd_vec_t rc [C];
  for (genvar i = 0; i < C; i++) begin : g_cordic
    tpw_pkg::cd_vec_t p_in, r_in;
    if (i == 0) begin : g_first
      assign p_in = pitch_in;
      assign r_in = roll_in;
    end else begin : g_next
      assign p_in = pc[i-1];
      assign r_in = rc[i-1];
    end
    tpw_cordic_cell u_pitch (
      .clk_i   (clk_i),
      .shift_i (5'(i)),
      .angle_i (tpw_pkg::atan_val(5'(i))),
      .in_i    (p_in),
      .out_o   (pc[i])
    );
    tpw_cordic_cell u_roll (
      .clk_i   (clk_i),
      .shift_i (5'(i)),
      .angle_i (tpw_pkg::atan_val(5'(i))),
      .in_i    (r_in),
      .out_o   (rc[i])
    );
  end

  // Round the accumulated angle to 1/64 degree and clamp; a zero vector gives zero.
  function automatic logic signed [14:0] ang_out(input tpw_pkg::cd_vec_t v);
    logic signed [tpw_pkg::ACC_W-1:0] r;
    r = (v.acc + tpw_pkg::ACC_W'(128)) >>> 8;
    if (v.zero)                              return '0;
    else if (r > tpw_pkg::ACC_W'(11520))     return tpw_pkg::ANGLE_LIMIT;
    else if (r < -tpw_pkg::ACC_W'(11520))    return -tpw_pkg::ANGLE_LIMIT;
    else                                     return r[14:0];
  endfunction

  logic signed [14:0] pitch, roll;
  logic signed [17:0] bp, br, th, pe, re;
  assign pitch = ang_out(pc[C-1]);
  assign roll  = ang_out(rc[C-1]);
  assign bp    = 18'(cfg.base_pitch);
  assign br    = 18'(cfg.base_roll);
  assign th    = $signed({4'd0, cfg.threshold});
  assign pe    = 18'(pitch) - bp;
  assign re    = 18'(roll) - br;

  // Output register.
  tpw_pkg::avg_t      avg_q;
  logic signed [14:0] pitch_q, roll_q;
  logic signed [15:0] pe_q, re_q;
  logic               good_q;

  always_ff @(posedge clk_i) begin
    avg_q   <= line_q[tpw_pkg::LINE_LEN-1];
    pitch_q <= pitch;
    roll_q  <= roll;
    pe_q    <= pe[15:0];
    re_q    <= re[15:0];
    good_q  <= (pe >= -th) && (pe <= th) && (re >= -th) && (re <= th);
  end

  assign done_o         = done_q;
  assign avg_x_o        = avg_q.x;
  assign avg_y_o        = avg_q.y;
  assign avg_z_o        = avg_q.z;
  assign pitch_angle_o  = pitch_q;
  assign roll_angle_o   = roll_q;
  assign pitch_error_o  = pe_q;
  assign roll_error_o   = re_q;
  assign posture_good_o = good_q;

endmodule

// ===== rtl/core/tpw_checker.sv =====
// ----------------------------------------------------------------------------
// Tilt posture port checker
// Watches the top-level ports for result timing and value ranges.
// ----------------------------------------------------------------------------
module tpw_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               done_o,
  input logic signed [14:0] pitch_angle_o,
  input logic signed [14:0] roll_angle_o
);

  // Every request that is taken gives a result on done_o.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##(tpw_pkg::LATENCY) done_o)
    else $error("missing result after request");

  // No result appears without a request.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, tpw_pkg::LATENCY))
    else $error("result without request");

  // Angles stay within a half turn.
  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (pitch_angle_o <= 15'sd11520) && (pitch_angle_o >= -15'sd11520))
    else $error("pitch out of range");

  a_roll_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (roll_angle_o <= 15'sd11520) && (roll_angle_o >= -15'sd11520))
    else $error("roll out of range");

endmodule

bind tilt_posture_window_check tpw_checker u_tpw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .done_o        (done_o),
  .pitch_angle_o (pitch_angle_o),
  .roll_angle_o  (roll_angle_o)
);
